@@ sv/saao_pkg.sv @@
// shared types and constants for the spiral arm angle ordering block
`default_nettype none
package saao_pkg;

    localparam int MAX_ARMS    = 256;
    localparam int MAX_ECHOES  = 16;
    localparam int ANGLE_BITS  = 32;

    localparam int ARM_W       = 8;
    localparam int ECHO_W      = 4;
    localparam int ARMS_CNT_W  = 9;
    localparam int ECHO_CNT_W  = 5;
    localparam int MODE_W      = 3;
    localparam int ORDER_W     = 12;
    localparam int POS_W       = 13;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [MODE_W-1:0] {
        ORD_LINEAR  = 3'd0,
        ORD_SKIP    = 3'd1,
        ORD_TWO_WAY = 3'd2,
        ORD_MIXED   = 3'd3,
        ORD_GOLDEN  = 3'd4
    } order_mode_t;

    typedef enum logic [2:0] {
        REG_ORDER_MODE = 3'd0,
        REG_ARM_COUNT  = 3'd1,
        REG_ECHO_COUNT = 3'd2,
        REG_INCOHERENT = 3'd3,
        REG_ANGLE_STEP = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [MODE_W-1:0]     order_mode;
        logic [ARMS_CNT_W-1:0] arm_count;
        logic [ECHO_CNT_W-1:0] echo_count;
        logic                  incoherent_mode;
        logic [ANGLE_BITS-1:0] angle_step;
    } cfg_t;

    typedef struct packed {
        logic [ORDER_W-1:0] order_index;
        logic [ORDER_W-1:0] flat_position;
        logic               range_error;
    } map_result_t;

endpackage
`default_nettype wire

@@ sv/saao_apb_regs.sv @@
// apb configuration registers
`default_nettype none
module saao_apb_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [saao_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [saao_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [saao_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output saao_pkg::cfg_t                           cfg
);

    saao_pkg::cfg_t cfg_reg;
    saao_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic [2:0]     reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                saao_pkg::REG_ORDER_MODE: cfg_next.order_mode =
                    pwdata[saao_pkg::MODE_W-1:0];
                saao_pkg::REG_ARM_COUNT: cfg_next.arm_count =
                    pwdata[saao_pkg::ARMS_CNT_W-1:0];
                saao_pkg::REG_ECHO_COUNT: cfg_next.echo_count =
                    pwdata[saao_pkg::ECHO_CNT_W-1:0];
                saao_pkg::REG_INCOHERENT: cfg_next.incoherent_mode = pwdata[0];
                saao_pkg::REG_ANGLE_STEP: cfg_next.angle_step =
                    pwdata[saao_pkg::ANGLE_BITS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.order_mode      <= saao_pkg::ORD_LINEAR;
            cfg_reg.arm_count       <= saao_pkg::ARMS_CNT_W'(1);
            cfg_reg.echo_count      <= saao_pkg::ECHO_CNT_W'(1);
            cfg_reg.incoherent_mode <= 1'b0;
            cfg_reg.angle_step      <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            saao_pkg::REG_ORDER_MODE:
                prdata = saao_pkg::APB_DATA_W'(cfg_reg.order_mode);
            saao_pkg::REG_ARM_COUNT:
                prdata = saao_pkg::APB_DATA_W'(cfg_reg.arm_count);
            saao_pkg::REG_ECHO_COUNT:
                prdata = saao_pkg::APB_DATA_W'(cfg_reg.echo_count);
            saao_pkg::REG_INCOHERENT:
                prdata = saao_pkg::APB_DATA_W'(cfg_reg.incoherent_mode);
            saao_pkg::REG_ANGLE_STEP:
                prdata = saao_pkg::APB_DATA_W'(cfg_reg.angle_step);
            default: prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/saao_order_map.sv @@
// flat position, range check and acquisition order mapping
`default_nettype none
module saao_order_map (
    input  wire saao_pkg::cfg_t                   cfg,
    input  wire logic [saao_pkg::ARM_W-1:0]       arm_index,
    input  wire logic [saao_pkg::ECHO_W-1:0]      echo_index,
    output saao_pkg::map_result_t                 result
);

    localparam int PW = saao_pkg::POS_W;

    logic [saao_pkg::ARMS_CNT_W-1:0] arms;
    logic [saao_pkg::ECHO_CNT_W-1:0] echoes;
    logic [PW-1:0]                   total;
    logic [PW-1:0]                   pos;
    logic [PW-1:0]                   half;
    logic [PW-1:0]                   evens;
    logic [PW-1:0]                   k;
    logic [PW-1:0]                   ord;
    logic                            err;

    always_comb begin
        if (cfg.arm_count == '0) begin
            arms = saao_pkg::ARMS_CNT_W'(1);
        end else if (cfg.arm_count > saao_pkg::ARMS_CNT_W'(saao_pkg::MAX_ARMS)) begin
            arms = saao_pkg::ARMS_CNT_W'(saao_pkg::MAX_ARMS);
        end else begin
            arms = cfg.arm_count;
        end
        if (cfg.echo_count == '0) begin
            echoes = saao_pkg::ECHO_CNT_W'(1);
        end else if (cfg.echo_count > saao_pkg::ECHO_CNT_W'(saao_pkg::MAX_ECHOES)) begin
            echoes = saao_pkg::ECHO_CNT_W'(saao_pkg::MAX_ECHOES);
        end else begin
            echoes = cfg.echo_count;
        end
    end

    always_comb begin
        if (cfg.incoherent_mode) begin
            total = PW'(PW'(arms) * PW'(echoes));
            pos   = PW'(PW'(arm_index) + PW'(PW'(echo_index) * PW'(arms)));
        end else begin
            total = PW'(arms);
            pos   = PW'(arm_index);
        end
        err = (PW'(arm_index) >= PW'(arms)) || (echo_index >= echoes) || (pos >= total);
        half  = total >> 1;
        evens = PW'(total + PW'(1)) >> 1;
        k     = pos - half;
    end

    always_comb begin
        unique case (cfg.order_mode)
            saao_pkg::ORD_SKIP: begin
                if (pos < evens) begin
                    ord = pos << 1;
                end else begin
                    ord = PW'(((pos - evens) << 1) + PW'(1));
                end
            end
            saao_pkg::ORD_TWO_WAY: begin
                if (pos[0]) begin
                    ord = PW'(total - PW'(1) - (pos >> 1));
                end else begin
                    ord = pos >> 1;
                end
            end
            saao_pkg::ORD_MIXED: begin
                if (pos < half) begin
                    ord = pos[0] ? PW'(total - PW'(2) - (pos << 1))
                                 : PW'(PW'(1) + (pos << 1));
                end else begin
                    ord = pos[0] ? PW'(k << 1) : PW'(total - PW'(1) - (k << 1));
                end
            end
            default: ord = pos;
        endcase
    end

    assign result.order_index   = err ? '0 : ord[saao_pkg::ORDER_W-1:0];
    assign result.flat_position = pos[saao_pkg::ORDER_W-1:0];
    assign result.range_error   = err;

endmodule
`default_nettype wire

@@ sv/spiral_arm_angle_order.sv @@
// spiral arm angle ordering top level: input stage, order map stage, angle multiply stage
// an accepted beat passes the input, order map and output registers before m_tvalid
// throughput: one beat per cycle, set by the three registered stages; stalls by m_tready
// the angle multiply (32 x 12 bits) has a stage of its own
// reset: synchronous active low aresetn clears the stage valids and loads the
// register defaults (linear order, one arm, one echo, coherent, zero step)
`default_nettype none
module spiral_arm_angle_order (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [15:0]                       s_tdata,  // arm_index, echo_index
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [55:0]                       m_tdata,  // order_index, flat_position, angle_turns
    output logic                                   m_tuser,  // range_error
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [saao_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [saao_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [saao_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    saao_pkg::cfg_t        cfg;
    saao_pkg::map_result_t map_res;

    logic                           in_valid_reg;
    logic [saao_pkg::ARM_W-1:0]     arm_reg;
    logic [saao_pkg::ECHO_W-1:0]    echo_reg;
    logic                           map_valid_reg;
    saao_pkg::map_result_t          map_reg;
    logic                           out_valid_reg;
    logic [saao_pkg::ORDER_W-1:0]   order_reg;
    logic [saao_pkg::ORDER_W-1:0]   flat_reg;
    logic [saao_pkg::ANGLE_BITS-1:0] angle_reg;
    logic                           err_reg;
    logic [saao_pkg::ANGLE_BITS+saao_pkg::ORDER_W-1:0] product;

    logic out_ready;
    logic map_ready;
    logic in_ready;

    saao_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    saao_order_map u_map (
        .cfg        (cfg),
        .arm_index  (arm_reg),
        .echo_index (echo_reg),
        .result     (map_res)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign map_ready = !map_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || map_ready;
    assign s_tready  = in_ready;

    assign product = cfg.angle_step * map_reg.order_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            map_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_tvalid;
            end
            if (map_ready) begin
                map_valid_reg <= in_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= map_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            arm_reg  <= s_tdata[7:0];
            echo_reg <= s_tdata[11:8];
        end
        if (map_ready && in_valid_reg) begin
            map_reg <= map_res;
        end
        if (out_ready && map_valid_reg) begin
            order_reg <= map_reg.order_index;
            flat_reg  <= map_reg.flat_position;
            angle_reg <= product[saao_pkg::ANGLE_BITS-1:0];
            err_reg   <= map_reg.range_error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {angle_reg, flat_reg, order_reg};
    assign m_tuser  = err_reg;

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for spiral_arm_angle_order: directed and random queries against a local model
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int MAX_PRINTS     = 40;
    localparam logic [31:0] GOLDEN_STEP = 32'h61C8_8647;

    typedef struct packed {
        logic [11:0] order_index;
        logic [11:0] flat_position;
        logic [31:0] angle_turns;
        logic        range_error;
    } arm_angle_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;   // arm_index, echo_index
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [55:0]           m_tdata;        // order_index, flat_position, angle_turns
    logic                  m_tuser;        // range_error
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [saao_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [saao_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [saao_pkg::APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic [2:0]  cfg_mode = 3'd0;
    logic [8:0]  cfg_arms = 9'd1;
    logic [4:0]  cfg_echoes = 5'd1;
    logic        cfg_incoherent = 1'b0;
    logic [31:0] cfg_step = 32'd0;

    arm_angle_t  pending_angles[$];
    int          error_count = 0;
    int          rx_hold = 0;
    int          idle_cycles = 0;
    bit          steady = 1'b0;

    spiral_arm_angle_order u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned effective_count(int unsigned value, int unsigned hi);
        if (value < 1) return 1;
        if (value > hi) return hi;
        return value;
    endfunction

    function automatic arm_angle_t compute_arm_angle(logic [7:0] arm, logic [3:0] echo);
        int unsigned arms, echoes, total, pos, ord, half, k;
        longint unsigned prod;
        arm_angle_t r;
        arms   = effective_count(cfg_arms, saao_pkg::MAX_ARMS);
        echoes = effective_count(cfg_echoes, saao_pkg::MAX_ECHOES);
        total  = cfg_incoherent ? arms * echoes : arms;
        pos    = cfg_incoherent ? arm + echo * arms : arm;
        r.range_error   = (arm >= arms) || (echo >= echoes) || (pos >= total);
        r.flat_position = pos[11:0];
        r.order_index   = '0;
        r.angle_turns   = '0;
        if (!r.range_error) begin
            case (cfg_mode)
                saao_pkg::ORD_SKIP: begin
                    half = (total + 1) / 2;
                    ord = (pos < half) ? 2 * pos : 2 * (pos - half) + 1;
                end
                saao_pkg::ORD_TWO_WAY: ord = pos[0] ? total - 1 - pos / 2 : pos / 2;
                saao_pkg::ORD_MIXED: begin
                    half = total / 2;
                    if (pos < half) begin
                        ord = pos[0] ? total - 2 - 2 * pos : 1 + 2 * pos;
                    end else begin
                        k = pos - half;
                        ord = pos[0] ? 2 * k : total - 1 - 2 * k;
                    end
                end
                default: ord = pos;
            endcase
            prod = longint'(cfg_step) * longint'(ord);
            r.order_index = ord[11:0];
            r.angle_turns = prod[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // beat check at the falling edge ahead of the accepting edge
    always @(negedge aclk) begin
        arm_angle_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_angles.size() == 0) begin
                report_mismatch("unexpected beat", 32'd0, m_tdata[31:0]);
            end else begin
                want = pending_angles.pop_front();
                if (m_tdata[11:0] !== want.order_index)
                    report_mismatch("order_index", want.order_index, m_tdata[11:0]);
                if (m_tdata[23:12] !== want.flat_position)
                    report_mismatch("flat_position", want.flat_position, m_tdata[23:12]);
                if (m_tdata[55:24] !== want.angle_turns)
                    report_mismatch("angle_turns", want.angle_turns, m_tdata[55:24]);
                if (m_tuser !== want.range_error)
                    report_mismatch("range_error", want.range_error, m_tuser);
            end
            rx_hold = steady ? 0 : $urandom_range(0, 6);
        end else if (rx_hold > 0) begin
            rx_hold--;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (rx_hold == 0);
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("spiral_arm_angle_order regression: fail");
        $finish;
    end

    task automatic send_query(logic [7:0] arm, logic [3:0] echo);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, echo, arm};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        pending_angles.push_back(compute_arm_angle(arm, echo));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic apb_write(saao_pkg::reg_index_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        @(posedge aclk);
        case (idx)
            saao_pkg::REG_ORDER_MODE: cfg_mode       = value[2:0];
            saao_pkg::REG_ARM_COUNT:  cfg_arms       = value[8:0];
            saao_pkg::REG_ECHO_COUNT: cfg_echoes     = value[4:0];
            saao_pkg::REG_INCOHERENT: cfg_incoherent = value[0];
            saao_pkg::REG_ANGLE_STEP: cfg_step       = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] mode, logic [31:0] arms, logic [31:0] echoes,
                              logic [31:0] incoherent, logic [31:0] step);
        drain_results();
        apb_write(saao_pkg::REG_ORDER_MODE, mode);
        apb_write(saao_pkg::REG_ARM_COUNT, arms);
        apb_write(saao_pkg::REG_ECHO_COUNT, echoes);
        apb_write(saao_pkg::REG_INCOHERENT, incoherent);
        apb_write(saao_pkg::REG_ANGLE_STEP, step);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_reset_values();
        send_query(8'd0, 4'd0);
        send_query(8'd1, 4'd0);
        send_query(8'd0, 4'd1);
    endtask

    task automatic test_field_extremes();
        set_config(saao_pkg::ORD_LINEAR, 256, 16, 1, 32'hFFFF_FFFF);
        send_query(8'd0, 4'd0);
        send_query(8'd255, 4'd15);
        send_query(8'd128, 4'd8);
    endtask

    task automatic test_order_modes();
        for (int m = 0; m < 8; m++) begin
            set_config(m, (m % 2 == 0) ? 7 : 8, 3, 1, GOLDEN_STEP);
            send_query(8'($urandom_range(0, 6)), 4'($urandom_range(0, 2)));
            send_query(8'($urandom_range(0, 6)), 4'($urandom_range(0, 2)));
        end
    endtask

    task automatic test_count_clamp();
        set_config(saao_pkg::ORD_TWO_WAY, 0, 0, 1, 32'h1000_0000);
        send_query(8'd0, 4'd0);
        send_query(8'd1, 4'd0);
        set_config(saao_pkg::ORD_MIXED, 511, 31, 1, 32'h0100_0001);
        send_query(8'd255, 4'd15);
        // echo left out of the position but still range checked
        set_config(saao_pkg::ORD_SKIP, 12, 4, 0, 32'h2000_0000);
        send_query(8'd5, 4'd9);
    endtask

    task automatic test_random_queries();
        int unsigned arms_in_use, echoes_in_use, arms_pick, echoes_pick, step_pick;
        logic [31:0] step;
        for (int phase = 0; phase < 14; phase++) begin
            case ($urandom_range(0, 9))
                0: arms_pick = 0;
                1: arms_pick = $urandom_range(257, 511);
                2: arms_pick = 256;
                3, 4, 5: arms_pick = $urandom_range(1, 256);
                default: arms_pick = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 7))
                0: echoes_pick = 0;
                1: echoes_pick = $urandom_range(17, 31);
                2: echoes_pick = 16;
                default: echoes_pick = $urandom_range(1, 16);
            endcase
            step_pick = $urandom_range(0, 4);
            case (step_pick)
                0: step = 32'd0;
                1: step = 32'hFFFF_FFFF;
                2: step = GOLDEN_STEP;
                default: step = $urandom;
            endcase
            set_config($urandom_range(0, 7), arms_pick, echoes_pick, $urandom_range(0, 1), step);
            arms_in_use   = effective_count(cfg_arms, saao_pkg::MAX_ARMS);
            echoes_in_use = effective_count(cfg_echoes, saao_pkg::MAX_ECHOES);
            for (int i = 0; i < 125; i++) begin
                if (i % 25 == 0) steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) < 85)
                    send_query(8'($urandom_range(0, arms_in_use - 1)),
                               4'($urandom_range(0, echoes_in_use - 1)));
                else
                    send_query(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_field_extremes();
        test_order_modes();
        test_count_clamp();
        test_random_queries();
        drain_results();
        if (error_count == 0 && pending_angles.size() == 0) begin
            $display("spiral_arm_angle_order regression: pass");
        end else begin
            $display("spiral_arm_angle_order regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ spiral_arm_angle_order.f @@
sv/saao_pkg.sv
sv/saao_apb_regs.sv
sv/saao_order_map.sv
sv/spiral_arm_angle_order.sv
verif/testbench.sv
